### design/hsa_pkg.sv
// Shared types, sizes and codes for the handle slot allocator.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package hsa_pkg;

    // Table sizes
    localparam int SLOTS     = 1024;
    localparam int SIZE_BITS = 32;
    localparam int REF_BITS  = 16;
    localparam int SLOT_W    = $clog2(SLOTS);
    localparam int HEAD_W    = $clog2(SLOTS + 1);

    // Port field widths
    localparam int OP_W     = 3;
    localparam int HANDLE_W = 11;
    localparam int BYTES_W  = 32;
    localparam int STATUS_W = 3;

    // Queue between front and back
    localparam int QDEPTH = 2;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    // Operation codes
    localparam logic [OP_W-1:0] OPC_ALLOC    = 3'd0;
    localparam logic [OP_W-1:0] OPC_RELEASE  = 3'd1;
    localparam logic [OP_W-1:0] OPC_ACCESS   = 3'd2;
    localparam logic [OP_W-1:0] OPC_UNACCESS = 3'd3;
    localparam logic [OP_W-1:0] OPC_GETSIZE  = 3'd4;

    // Result status codes
    localparam logic [STATUS_W-1:0] STATUS_OK    = 3'd0;
    localparam logic [STATUS_W-1:0] STATUS_FULL  = 3'd1;
    localparam logic [STATUS_W-1:0] STATUS_RANGE = 3'd2;
    localparam logic [STATUS_W-1:0] STATUS_DEAD  = 3'd3;
    localparam logic [STATUS_W-1:0] STATUS_BUSY  = 3'd4;

    // Classified operation as decided by the front end
    typedef enum logic [2:0] {
        K_ALLOC,
        K_RELEASE,
        K_ACCESS,
        K_UNACCESS,
        K_GETSIZE,
        K_NULL_OK,
        K_BAD
    } op_kind_t;

    // One queued item
    typedef struct packed {
        op_kind_t              kind;
        logic [SLOT_W-1:0]     slot;
        logic [SIZE_BITS-1:0]  size;
    } item_t;

    // One slot table entry
    typedef struct packed {
        logic                  live;
        logic [REF_BITS-1:0]   refs;
        logic [SIZE_BITS-1:0]  size;
        logic [HEAD_W-1:0]     next;
    } slot_entry_t;

    // Back end sequencer
    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EXEC
    } back_state_t;

endpackage

### design/handle_slot_allocator.sv
// Handle slot allocator: LIFO free list of slots with size and reference count.
// Flow: front queue, slot read (ST_IDLE), then update and result (ST_EXEC).
// One item at a time: each reads then writes the slot memory before the next.
// Reset: a clearing pass walks all SLOTS (1024) slots of the memory; input stalls.
// Top level; depends on hsa_pkg, hsa_front and hsa_back.
`timescale 1ns / 1ps

module handle_slot_allocator
    import hsa_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [OP_W-1:0]      operation,
    input  logic [HANDLE_W-1:0]  handle,
    input  logic [BYTES_W-1:0]   byte_count,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic                 ok,
    output logic [STATUS_W-1:0]  status,
    output logic [HANDLE_W-1:0]  new_handle,
    output logic [BYTES_W-1:0]   size_out
);

    logic   q_valid;
    item_t  q_entry;
    logic   q_pop;
    logic   clearing;

    // Accept and classify
    hsa_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .enable     (!clearing),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .operation  (operation),
        .handle     (handle),
        .byte_count (byte_count),
        .q_valid    (q_valid),
        .q_entry    (q_entry),
        .q_pop      (q_pop)
    );

    // Carry out against the slot table
    hsa_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_valid    (q_valid),
        .q_entry    (q_entry),
        .q_pop      (q_pop),
        .clearing   (clearing),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .ok         (ok),
        .status     (status),
        .new_handle (new_handle),
        .size_out   (size_out)
    );

`ifndef SYNTHESIS
    // No result while the slot memory is being cleared
    a_no_result_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        clearing |-> !out_valid)
        else $error("result presented during clearing pass");

    // ok and status agree
    a_ok_status: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (ok == (status == STATUS_OK)))
        else $error("ok flag disagrees with status");

    // A failed item carries no handle and no size
    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !ok) |-> (new_handle == '0 && size_out == '0))
        else $error("failed item carries payload");

    // Queue is never popped while the clearing pass runs
    a_no_pop_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        clearing |-> !q_pop)
        else $error("queue popped during clearing pass");
`endif

endmodule

### design/hsa_front.sv
// Front end: accepts items, range-checks and classifies them, and queues them.
// Depends on hsa_pkg.
`timescale 1ns / 1ps

module hsa_front
    import hsa_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 enable,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [OP_W-1:0]      operation,
    input  logic [HANDLE_W-1:0]  handle,
    input  logic [BYTES_W-1:0]   byte_count,
    output logic                 q_valid,
    output item_t                q_entry,
    input  logic                 q_pop
);

    item_t               q_mem [QDEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]   count_reg, count_next;
    logic                push;
    logic [31:0]         handle_ext;
    logic                in_range;
    item_t               cls;

    // Classify the incoming item
    always_comb
    begin
        handle_ext = 32'(handle);
        in_range   = (handle_ext != 32'd0) && (handle_ext <= 32'(SLOTS));
        cls.slot   = SLOT_W'(handle_ext - 32'd1);
        cls.size   = SIZE_BITS'(byte_count);
        case (operation)
            OPC_ALLOC:    cls.kind = K_ALLOC;
            OPC_RELEASE:
            begin
                if (handle_ext == 32'd0)
                    cls.kind = K_NULL_OK;
                else
                    cls.kind = in_range ? K_RELEASE : K_BAD;
            end
            OPC_ACCESS:   cls.kind = in_range ? K_ACCESS : K_BAD;
            OPC_UNACCESS: cls.kind = in_range ? K_UNACCESS : K_BAD;
            OPC_GETSIZE:  cls.kind = in_range ? K_GETSIZE : K_BAD;
            default:      cls.kind = K_BAD;
        endcase
    end

    // Queue control
    assign in_stall = (count_reg == QCNT_W'(QDEPTH)) || !enable;
    assign push     = in_valid && !in_stall;
    assign q_valid  = (count_reg != '0);
    assign q_entry  = q_mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (q_pop)
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        case ({push, q_pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Queue storage
    always_ff @(posedge clk)
    begin
        if (push)
            q_mem[wr_ptr_reg] <= cls;
    end

endmodule

### design/hsa_back.sv
// Back end: slot table memory, free list head and the result register.
// Depends on hsa_pkg; fed by the hsa_front queue.
`timescale 1ns / 1ps

module hsa_back
    import hsa_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 q_valid,
    input  item_t                q_entry,
    output logic                 q_pop,
    output logic                 clearing,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic                 ok,
    output logic [STATUS_W-1:0]  status,
    output logic [HANDLE_W-1:0]  new_handle,
    output logic [BYTES_W-1:0]   size_out
);

    slot_entry_t           mem [SLOTS];
    slot_entry_t           rd_reg;
    slot_entry_t           wd;
    logic                  we;
    logic                  re;
    logic [SLOT_W-1:0]     wa;
    logic [SLOT_W-1:0]     ra;

    back_state_t           state_reg, state_next;
    logic [SLOT_W-1:0]     clr_reg, clr_next;
    logic [HEAD_W-1:0]     head_reg, head_next;
    item_t                 cur_reg, cur_next;

    logic                  out_valid_reg, out_valid_next;
    logic                  ok_reg;
    logic [STATUS_W-1:0]   status_reg;
    logic [HANDLE_W-1:0]   new_handle_reg;
    logic [BYTES_W-1:0]    size_out_reg;

    logic                  out_load;
    logic                  res_ok;
    logic [STATUS_W-1:0]   res_status;
    logic [HANDLE_W-1:0]   res_handle;
    logic [BYTES_W-1:0]    res_size;
    logic                  res_we;
    slot_entry_t           res_wd;
    logic [HEAD_W-1:0]     res_head;
    logic                  list_empty;

    assign out_load   = !out_valid_reg || !out_stall;
    assign list_empty = (head_reg >= HEAD_W'(SLOTS));

    // Work out the result of the current item from the slot read back
    always_comb
    begin
        res_ok     = 1'b0;
        res_status = STATUS_RANGE;
        res_handle = '0;
        res_size   = '0;
        res_we     = 1'b0;
        res_wd     = rd_reg;
        res_head   = head_reg;
        case (cur_reg.kind)
            K_ALLOC:
            begin
                if (list_empty)
                    res_status = STATUS_FULL;
                else
                begin
                    res_ok      = 1'b1;
                    res_status  = STATUS_OK;
                    res_handle  = HANDLE_W'(HEAD_W'({1'b0, head_reg} + 1'b1));
                    res_we      = 1'b1;
                    res_wd.live = 1'b1;
                    res_wd.refs = '0;
                    res_wd.size = cur_reg.size;
                    res_head    = rd_reg.next;
                end
            end
            K_RELEASE:
            begin
                if (!rd_reg.live)
                    res_status = STATUS_DEAD;
                else if (rd_reg.refs != '0)
                    res_status = STATUS_BUSY;
                else
                begin
                    res_ok      = 1'b1;
                    res_status  = STATUS_OK;
                    res_we      = 1'b1;
                    res_wd.live = 1'b0;
                    res_wd.next = head_reg;
                    res_head    = HEAD_W'(cur_reg.slot);
                end
            end
            K_ACCESS, K_UNACCESS:
            begin
                if (!rd_reg.live)
                    res_status = STATUS_DEAD;
                else
                begin
                    res_ok     = 1'b1;
                    res_status = STATUS_OK;
                    res_we     = 1'b1;
                    if (cur_reg.kind == K_ACCESS)
                    begin
                        if (rd_reg.refs != '1)
                            res_wd.refs = rd_reg.refs + 1'b1;
                    end
                    else if (rd_reg.refs != '0)
                        res_wd.refs = rd_reg.refs - 1'b1;
                end
            end
            K_GETSIZE:
            begin
                if (!rd_reg.live)
                    res_status = STATUS_DEAD;
                else
                begin
                    res_ok     = 1'b1;
                    res_status = STATUS_OK;
                    res_size   = BYTES_W'(rd_reg.size);
                end
            end
            K_NULL_OK:
            begin
                res_ok     = 1'b1;
                res_status = STATUS_OK;
            end
            default:
            begin
                res_status = STATUS_RANGE;
            end
        endcase
    end

    // Sequencer: clearing pass, then read slot, then update and report
    always_comb
    begin
        state_next     = state_reg;
        clr_next       = clr_reg;
        head_next      = head_reg;
        cur_next       = cur_reg;
        out_valid_next = out_valid_reg && out_stall;
        q_pop          = 1'b0;
        we             = 1'b0;
        wa             = cur_reg.slot;
        wd             = res_wd;
        re             = 1'b0;
        ra             = (q_entry.kind == K_ALLOC) ? head_reg[SLOT_W-1:0] : q_entry.slot;
        case (state_reg)
            ST_CLEAR:
            begin
                we      = 1'b1;
                wa      = clr_reg;
                wd.live = 1'b0;
                wd.refs = '0;
                wd.size = '0;
                wd.next = HEAD_W'({1'b0, clr_reg} + 1'b1);
                clr_next = clr_reg + 1'b1;
                if (clr_reg == SLOT_W'(SLOTS - 1))
                    state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop      = 1'b1;
                    re         = 1'b1;
                    cur_next   = q_entry;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (out_load)
                begin
                    we             = res_we;
                    if (cur_reg.kind == K_ALLOC)
                        wa = head_reg[SLOT_W-1:0];
                    head_next      = res_head;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_reg       <= '0;
            head_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            head_reg      <= head_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Item and result payload
    always_ff @(posedge clk)
    begin
        cur_reg <= cur_next;
        if (state_reg == ST_EXEC && out_load)
        begin
            ok_reg         <= res_ok;
            status_reg     <= res_status;
            new_handle_reg <= res_handle;
            size_out_reg   <= res_size;
        end
    end

    // Slot table
    always_ff @(posedge clk)
    begin
        if (we)
            mem[wa] <= wd;
        if (re)
            rd_reg <= mem[ra];
    end

    assign clearing   = (state_reg == ST_CLEAR);
    assign out_valid  = out_valid_reg;
    assign ok         = ok_reg;
    assign status     = status_reg;
    assign new_handle = new_handle_reg;
    assign size_out   = size_out_reg;

endmodule
